>>> src/vsc_pkg.sv
// ----------------------------------------------------------------------------
// vsc_pkg: shared types and constants of the voxel slab column decoder
// Request and result layouts, kind codes and result queue sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package vsc_pkg;

  // Request type codes.
  localparam logic REQ_BEGIN = 1'b0;
  localparam logic REQ_DATA  = 1'b1;

  // Result kind codes.
  localparam logic [1:0] KIND_VOXEL = 2'd0;
  localparam logic [1:0] KIND_FILL  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Bit positions in the face-mask byte.
  localparam int UP_BIT   = 4;
  localparam int DOWN_BIT = 5;

  // Result queue sizing.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One accepted request.
  typedef struct packed {
    logic        req_type;
    logic [7:0]  column_x;
    logic [7:0]  column_depth;
    logic [15:0] column_bytes;
    logic [7:0]  data_byte;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] x;
    logic [7:0] depth;
    logic [7:0] height_low;
    logic [7:0] height_high;
    logic [7:0] color_index;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

>>> src/vsc_core.sv
// ----------------------------------------------------------------------------
// vsc_core: slab parser state and per-request result generation
// Holds the column and slab state and turns one request into up to two
// results combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module vsc_core #(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_DEPTH = 256
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            req_fire,
  input  wire vsc_pkg::req_t   req,
  input  wire logic [7:0]      volume_height,
  output vsc_pkg::result_t     res0,
  output vsc_pkg::result_t     res1,
  output logic [1:0]           res_count
);

  typedef enum logic [1:0] {
    PH_TOP,
    PH_LEN,
    PH_FACE,
    PH_COLOR
  } phase_t;

  localparam logic [8:0] MaxW = 9'(MAX_WIDTH);
  localparam logic [8:0] MaxD = 9'(MAX_DEPTH);

  // Parser state.
  phase_t      phase_r, phase_nxt;
  logic [7:0]  top_r, top_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  seen_r, seen_nxt;
  logic [1:0]  face_r, face_nxt;
  logic [16:0] left_r, left_nxt;
  logic [7:0]  x_r, x_nxt;
  logic [7:0]  depth_r, depth_nxt;
  logic [8:0]  pse_r, pse_nxt;
  logic [7:0]  colour_r, colour_nxt;
  logic        cvalid_r, cvalid_nxt;

  logic        in_plane;
  logic [1:0]  face_in;
  logic [7:0]  seen_inc;

  // Voxel placement for the current colour byte.
  logic [8:0]  vox_z;
  logic        vox_ok;
  logic [7:0]  vox_h;

  // Fill span of a completed slab.
  logic [1:0]         fin_face;
  logic               fin_cvalid;
  logic [7:0]         fin_colour;
  logic signed [10:0] fill_lo;
  logic signed [10:0] fill_hi_raw;
  logic signed [10:0] vmax;
  logic signed [10:0] fill_hi;
  logic signed [10:0] fill_low_d;
  logic signed [10:0] fill_high_d;
  logic               fill_ok;
  vsc_pkg::result_t   base_res;
  vsc_pkg::result_t   vox_res;
  vsc_pkg::result_t   fill_res;

  assign in_plane = ({1'b0, x_r} < MaxW) && ({1'b0, depth_r} < MaxD);
  assign face_in  = {req.data_byte[vsc_pkg::DOWN_BIT], req.data_byte[vsc_pkg::UP_BIT]};
  assign seen_inc = seen_r + 8'd1;

  assign vox_z  = {1'b0, top_r} + {1'b0, seen_r};
  assign vox_ok = (vox_z < {1'b0, volume_height}) && in_plane;
  assign vox_h  = volume_height - 8'd1 - vox_z[7:0];

  // A slab completes on its face byte or on its last colour byte.
  assign fin_face   = (phase_r == PH_FACE) ? face_in : face_r;
  assign fin_cvalid = (phase_r == PH_COLOR) ? 1'b1 : cvalid_r;
  assign fin_colour = (phase_r == PH_COLOR) ? req.data_byte : colour_r;

  assign fill_lo     = $signed({2'b00, pse_r}) + 11'sd1;
  assign fill_hi_raw = $signed({3'b000, top_r}) - 11'sd1;
  assign vmax        = $signed({3'b000, volume_height}) - 11'sd1;
  assign fill_hi     = (fill_hi_raw > vmax) ? vmax : fill_hi_raw;
  assign fill_ok     = !fin_face[0] && fin_cvalid && in_plane && (fill_lo <= fill_hi);
  assign fill_low_d  = vmax - fill_hi;
  assign fill_high_d = vmax - fill_lo;

  always_comb begin
    base_res             = '0;
    base_res.x           = x_r;
    base_res.depth       = depth_r;

    vox_res              = base_res;
    vox_res.kind         = vsc_pkg::KIND_VOXEL;
    vox_res.height_low   = vox_h;
    vox_res.height_high  = vox_h;
    vox_res.color_index  = req.data_byte;

    fill_res             = base_res;
    fill_res.kind        = vsc_pkg::KIND_FILL;
    fill_res.height_low  = fill_low_d[7:0];
    fill_res.height_high = fill_high_d[7:0];
    fill_res.color_index = fin_colour;
  end

  // Next state and results for the request at the input register.
  always_comb begin
    logic finish;
    finish     = 1'b0;
    phase_nxt  = phase_r;
    top_nxt    = top_r;
    len_nxt    = len_r;
    seen_nxt   = seen_r;
    face_nxt   = face_r;
    left_nxt   = left_r;
    x_nxt      = x_r;
    depth_nxt  = depth_r;
    pse_nxt    = pse_r;
    colour_nxt = colour_r;
    cvalid_nxt = cvalid_r;
    res0       = '0;
    res1       = '0;
    res_count  = 2'd0;

    if (req.req_type == vsc_pkg::REQ_BEGIN) begin
      x_nxt     = req.column_x;
      depth_nxt = req.column_depth;
      left_nxt  = {1'b0, req.column_bytes};
      phase_nxt = PH_TOP;
      seen_nxt  = 8'd0;
    end else if (left_r == 17'd0) begin
      // Stray byte outside any column: report it, keep the state.
      res0      = base_res;
      res0.kind = vsc_pkg::KIND_ERROR;
      res_count = 2'd1;
    end else begin
      left_nxt = left_r - 17'd1;
      unique case (phase_r)
        PH_TOP: begin
          top_nxt   = req.data_byte;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          len_nxt   = req.data_byte;
          phase_nxt = PH_FACE;
        end
        PH_FACE: begin
          face_nxt = face_in;
          seen_nxt = 8'd0;
          if (len_r == 8'd0) begin
            finish = 1'b1;
          end else begin
            phase_nxt = PH_COLOR;
          end
        end
        PH_COLOR: begin
          if (vox_ok) begin
            res0      = vox_res;
            res_count = 2'd1;
          end
          colour_nxt = req.data_byte;
          cvalid_nxt = 1'b1;
          seen_nxt   = seen_inc;
          finish     = (seen_inc >= len_r);
        end
        default: begin
          phase_nxt = PH_TOP;
        end
      endcase

      if (finish) begin
        if (fill_ok) begin
          if (res_count == 2'd0) begin
            res0 = fill_res;
          end else begin
            res1 = fill_res;
          end
          res_count = res_count + 2'd1;
        end
        if (!fin_face[1]) begin
          pse_nxt = {1'b0, top_r} + {1'b0, len_r};
        end
        phase_nxt = PH_TOP;
      end
    end

    // Mark the final result of this request.
    if (res_count == 2'd1) begin
      res0.last = 1'b1;
    end else if (res_count == 2'd2) begin
      res1.last = 1'b1;
    end
  end

  // State registers, updated when the request leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TOP;
      top_r    <= '0;
      len_r    <= '0;
      seen_r   <= '0;
      face_r   <= '0;
      left_r   <= '0;
      x_r      <= '0;
      depth_r  <= '0;
      pse_r    <= '0;
      colour_r <= '0;
      cvalid_r <= 1'b0;
    end else if (req_fire) begin
      phase_r  <= phase_nxt;
      top_r    <= top_nxt;
      len_r    <= len_nxt;
      seen_r   <= seen_nxt;
      face_r   <= face_nxt;
      left_r   <= left_nxt;
      x_r      <= x_nxt;
      depth_r  <= depth_nxt;
      pse_r    <= pse_nxt;
      colour_r <= colour_nxt;
      cvalid_r <= cvalid_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/vsc_res_fifo.sv
// ----------------------------------------------------------------------------
// vsc_res_fifo: result queue
// Takes up to two results per cycle and hands one per cycle to the output while it is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module vsc_res_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [1:0]                    push_count,
  input  wire vsc_pkg::result_t              push0,
  input  wire vsc_pkg::result_t              push1,
  output logic                               room,
  output logic [vsc_pkg::QCNT_W-1:0]         count,
  output logic                               pop_valid,
  input  wire logic                          pop_ready,
  output vsc_pkg::result_t                   pop_data
);

  vsc_pkg::result_t                mem_r [vsc_pkg::QDEPTH];
  logic [vsc_pkg::QPTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [vsc_pkg::QCNT_W-1:0]      count_r;
  logic [vsc_pkg::QPTR_W-1:0]      wr_ptr1;
  logic                            pop;

  // Room for a full pair of results, judged on the stored count only.
  assign room      = (count_r <= vsc_pkg::QCNT_W'(vsc_pkg::QDEPTH - 2));
  assign count     = count_r;
  assign pop_valid = (count_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = mem_r[rd_ptr_r];
  assign wr_ptr1   = wr_ptr_r + vsc_pkg::QPTR_W'(1);

  // Storage writes.
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_count == 2'd2) begin
      mem_r[wr_ptr1] <= push1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + vsc_pkg::QPTR_W'(push_count);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + vsc_pkg::QPTR_W'(1);
      end
      count_r <= count_r + vsc_pkg::QCNT_W'(push_count) - vsc_pkg::QCNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

>>> src/voxel_slab_column_decoder.sv
// ----------------------------------------------------------------------------
// voxel_slab_column_decoder: slab stream decoder for one voxel column at a time
// How to use it:
//   The in_ channel takes requests: a begin-column request (in_req_type 0)
//   sets x, depth and the slab byte count; data requests (in_req_type 1)
//   then bring the slab top, length, face mask and colour bytes.
//   The out_ channel returns voxel writes, fill spans and stray-byte errors;
//   out_last marks the final result of a request. A request may give none,
//   one or two results.
//   The cfg_ channel writes volume_height; cfg_ready is always high. Write it
//   only while no request is in flight.
//   A request is held in the input register; its results are written to a
//   four-entry result queue when the request leaves that register and can
//   be taken from the queue after that.
//   Throughput: one request per cycle while the queue holds two entries or
//   fewer; the output drains one result per cycle, so a stream of requests
//   that give two results is held back by the output in steady state.
//   When the receiver stalls, the queue fills and in_ready drops; no result
//   is lost. Reset clears the parser state, the queue and the input register
//   and sets volume_height to 255. There is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_slab_column_decoder #(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Request channel.
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_req_type,
  input  wire logic [7:0]  in_column_x,
  input  wire logic [7:0]  in_column_depth,
  input  wire logic [15:0] in_column_bytes,
  input  wire logic [7:0]  in_data_byte,
  // Result channel.
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_x,
  output logic [7:0]       out_depth,
  output logic [7:0]       out_height_low,
  output logic [7:0]       out_height_high,
  output logic [7:0]       out_color_index,
  output logic             out_last,
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  logic                          stage_valid_r;
  vsc_pkg::req_t                 stage_r;
  logic                          stage_fire;
  logic [7:0]                    vheight_r;
  logic                          q_room;
  logic [vsc_pkg::QCNT_W-1:0]    q_count;
  logic [1:0]                    res_count;
  logic [1:0]                    push_count;
  vsc_pkg::result_t              res0, res1;
  vsc_pkg::result_t              head;

  // Input register: refills whenever its request moves on.
  assign stage_fire = stage_valid_r && q_room;
  assign in_ready   = !stage_valid_r || q_room;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_ready) begin
      stage_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_r.req_type     <= in_req_type;
      stage_r.column_x     <= in_column_x;
      stage_r.column_depth <= in_column_depth;
      stage_r.column_bytes <= in_column_bytes;
      stage_r.data_byte    <= in_data_byte;
    end
  end

  // Volume height register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vheight_r <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      vheight_r <= cfg_data;
    end
  end

  // Parser and result generation.
  vsc_core #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_fire      (stage_fire),
    .req           (stage_r),
    .volume_height (vheight_r),
    .res0          (res0),
    .res1          (res1),
    .res_count     (res_count)
  );

  assign push_count = stage_fire ? res_count : 2'd0;

  // Result queue.
  vsc_res_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_count (push_count),
    .push0      (res0),
    .push1      (res1),
    .room       (q_room),
    .count      (q_count),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .pop_data   (head)
  );

  assign out_kind        = head.kind;
  assign out_x           = head.x;
  assign out_depth       = head.depth;
  assign out_height_low  = head.height_low;
  assign out_height_high = head.height_high;
  assign out_color_index = head.color_index;
  assign out_last        = head.last;

  // The queue never holds more than its depth.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= vsc_pkg::QCNT_W'(vsc_pkg::QDEPTH))
    else $error("result queue overflow");

  // A request moves on only with room for a full pair of results.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push_count != 2'd0) |-> q_room)
    else $error("results pushed without room");

  // A stray-byte error is always the only and last result of its request.
  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == vsc_pkg::KIND_ERROR) |-> out_last)
    else $error("error result not marked last");

  // Results never carry an undefined kind.
  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == vsc_pkg::KIND_VOXEL || out_kind == vsc_pkg::KIND_FILL ||
                   out_kind == vsc_pkg::KIND_ERROR))
    else $error("undefined result kind");

endmodule

`default_nettype wire

>>> bench/voxel_slab_column_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_slab_column_decoder_tb: self-checking bench for the slab column decoder
// A queue of requests feeds a clocked driver that inserts random gaps. Every
// accepted request is decoded by a local slab parser, and the voxel writes,
// fill spans and stray-byte errors it predicts are compared against the
// result channel. The run steps through several volume heights. The height
// is rewritten only once all requests have drained.
// ----------------------------------------------------------------------------
module voxel_slab_column_decoder_tb;

  typedef enum logic [1:0] {P_TOP, P_LEN, P_FACE, P_COLOR} slab_field_t;

  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 190;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_req_type = vsc_pkg::REQ_BEGIN;
  logic [7:0]  in_column_x = '0;
  logic [7:0]  in_column_depth = '0;
  logic [15:0] in_column_bytes = '0;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_x;
  logic [7:0]  out_depth;
  logic [7:0]  out_height_low;
  logic [7:0]  out_height_high;
  logic [7:0]  out_color_index;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  voxel_slab_column_decoder i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_column_x     (in_column_x),
    .in_column_depth (in_column_depth),
    .in_column_bytes (in_column_bytes),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_x           (out_x),
    .out_depth       (out_depth),
    .out_height_low  (out_height_low),
    .out_height_high (out_height_high),
    .out_color_index (out_color_index),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  // Requests waiting to be driven and results still owed by the block.
  vsc_pkg::req_t    slab_requests[$];
  vsc_pkg::result_t voxel_results_due[$];
  int      item_count = 0;
  int      err_count = 0;
  int      cycles = 0;
  int      in_calm = 0;
  int      out_calm = 0;

  // Parser state of the predictor; all of it starts at zero but vol_height, which starts at 255.
  logic [7:0]  vol_height = 8'd255;
  slab_field_t st_field = P_TOP;
  logic [7:0]  st_top = '0;
  logic [7:0]  st_len = '0;
  logic [7:0]  st_seen = '0;
  logic        up_set = 1'b0;
  logic        down_set = 1'b0;
  logic [16:0] rem_bytes = '0;
  logic [7:0]  col_x = '0;
  logic [7:0]  col_depth = '0;
  logic [8:0]  floor_end = '0;
  logic [7:0]  last_color = '0;
  logic        color_seen = 1'b0;

  // Results produced by the request being decoded.
  vsc_pkg::result_t step_out[2];
  int      step_cnt;

  initial begin
    forever #5 clk = ~clk;
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void emit(logic [1:0] k, logic [7:0] lo, logic [7:0] hi, logic [7:0] c);
    step_out[step_cnt] = '{kind: k, x: col_x, depth: col_depth, height_low: lo,
                           height_high: hi, color_index: c, last: 1'b0};
    step_cnt++;
  endfunction

  // A finished slab may fill the gap above the previous slab end in the last
  // color, then moves that end down unless the down face is present. The
  // column always lies inside the plane, since x and depth are 8 bits wide.
  function automatic void close_slab();
    int lo;
    int hi;
    int vmax;
    lo = int'(floor_end) + 1;
    hi = int'(st_top) - 1;
    vmax = int'(vol_height) - 1;
    if (hi > vmax) hi = vmax;
    if (!up_set && color_seen && lo <= hi)
      emit(vsc_pkg::KIND_FILL, 8'(vmax - hi), 8'(vmax - lo), last_color);
    if (!down_set) floor_end = {1'b0, st_top} + {1'b0, st_len};
    st_field = P_TOP;
  endfunction

  // Decodes one accepted request and queues the results it causes.
  function automatic void decode_request(vsc_pkg::req_t r);
    int z;
    step_cnt = 0;
    if (r.req_type == vsc_pkg::REQ_BEGIN) begin
      col_x = r.column_x;
      col_depth = r.column_depth;
      rem_bytes = {1'b0, r.column_bytes};
      st_field = P_TOP;
      st_seen = '0;
      return;
    end
    if (rem_bytes == 0) begin
      // A byte beyond the column's count is flagged and changes nothing.
      emit(vsc_pkg::KIND_ERROR, 8'd0, 8'd0, 8'd0);
    end else begin
      rem_bytes--;
      case (st_field)
        P_TOP: begin
          st_top = r.data_byte;
          st_field = P_LEN;
        end
        P_LEN: begin
          st_len = r.data_byte;
          st_field = P_FACE;
        end
        P_FACE: begin
          up_set = r.data_byte[vsc_pkg::UP_BIT];
          down_set = r.data_byte[vsc_pkg::DOWN_BIT];
          st_seen = '0;
          if (st_len == 0) close_slab();
          else st_field = P_COLOR;
        end
        default: begin
          // Colors run from the slab top downward; heights are flipped.
          z = int'(st_top) + int'(st_seen);
          if (z < int'(vol_height))
            emit(vsc_pkg::KIND_VOXEL, 8'(int'(vol_height) - 1 - z),
                 8'(int'(vol_height) - 1 - z), r.data_byte);
          last_color = r.data_byte;
          color_seen = 1'b1;
          st_seen++;
          if (st_seen >= st_len) close_slab();
        end
      endcase
    end
    for (int i = 0; i < step_cnt; i++) begin
      step_out[i].last = (i == step_cnt - 1);
      voxel_results_due.insert(voxel_results_due.size(), step_out[i]);
    end
  endfunction

  // Gap length in cycles: mostly none, some short, a few long, and calm
  // stretches with no gaps at all.
  function automatic int next_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 299) == 0) begin
      calm = $urandom_range(30, 150);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      err_count++;
    end
  endfunction

  // Driver: a request stays on the bus unchanged until it is taken.
  always @(posedge clk) begin : driver
    vsc_pkg::req_t r;
    int   in_gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready)
        decode_request('{in_req_type, in_column_x, in_column_depth, in_column_bytes,
                         in_data_byte});
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (slab_requests.size() > 0) begin
          r = slab_requests.pop_front();
          in_valid <= 1'b1;
          in_req_type <= r.req_type;
          in_column_x <= r.column_x;
          in_column_depth <= r.column_depth;
          in_column_bytes <= r.column_bytes;
          in_data_byte <= r.data_byte;
          in_gap = next_gap(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each taken result with the oldest one owed.
  always @(posedge clk) begin : monitor
    vsc_pkg::result_t want;
    int      out_hold;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (voxel_results_due.size() == 0) begin
          $error("result with none expected: kind %0d x %0d depth %0d",
                 out_kind, out_x, out_depth);
          err_count++;
        end else begin
          want = voxel_results_due.pop_front();
          check_field("kind", want.kind, out_kind);
          check_field("x", want.x, out_x);
          check_field("depth", want.depth, out_depth);
          check_field("height_low", want.height_low, out_height_low);
          check_field("height_high", want.height_high, out_height_high);
          check_field("color_index", want.color_index, out_color_index);
          check_field("last", want.last, out_last);
        end
      end
      if (out_hold > 0) begin
        out_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_hold = next_gap(out_calm);
      end
    end
  end

  task automatic push_begin(int x, int d, int n);
    vsc_pkg::req_t r;
    r.req_type = vsc_pkg::REQ_BEGIN;
    r.column_x = 8'(x);
    r.column_depth = 8'(d);
    r.column_bytes = 16'(n);
    r.data_byte = 8'($urandom);
    slab_requests.insert(slab_requests.size(), r);
    item_count++;
  endtask

  task automatic push_byte(int b);
    vsc_pkg::req_t r;
    r.req_type = vsc_pkg::REQ_DATA;
    r.column_x = 8'($urandom);
    r.column_depth = 8'($urandom);
    r.column_bytes = 16'($urandom);
    r.data_byte = 8'(b);
    slab_requests.insert(slab_requests.size(), r);
    item_count++;
  endtask

  // Slab tops cluster at the ends of the range and around the clip height.
  function automatic int pick_top();
    int r;
    int t;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(0, 255);
    if (r < 7) begin
      t = int'(vol_height) - 3 + $urandom_range(0, 5);
      return (t < 0) ? 0 : ((t > 255) ? 255 : t);
    end
    if (r == 7) return 0;
    if (r == 8) return 255;
    return $urandom_range(0, 10);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 4);
    if (r < 98) return $urandom_range(5, 20);
    return $urandom_range(21, 255);
  endfunction

  // One column: mostly well formed, sometimes with a short count, a cut-off
  // slab, a garbage count or trailing stray bytes.
  task automatic gen_column();
    logic [7:0] col_bytes[$];
    int nslab;
    int len;
    int cnt;
    int mode;
    nslab = $urandom_range(0, 3);
    for (int s = 0; s < nslab; s++) begin
      len = pick_len();
      col_bytes.insert(col_bytes.size(), 8'(pick_top()));
      col_bytes.insert(col_bytes.size(), 8'(len));
      col_bytes.insert(col_bytes.size(), 8'($urandom));
      repeat (len) col_bytes.insert(col_bytes.size(), 8'($urandom));
    end
    cnt = col_bytes.size();
    mode = $urandom_range(0, 19);
    if (mode == 0 && cnt > 0) begin
      cnt = $urandom_range(0, cnt - 1);
    end else if (mode == 1 && cnt > 0) begin
      repeat ($urandom_range(1, 3)) if (col_bytes.size() > 0) void'(col_bytes.pop_back());
    end else if (mode == 2) begin
      cnt = $urandom_range(0, 65535);
    end
    push_begin($urandom_range(0, 255), $urandom_range(0, 255), cnt);
    foreach (col_bytes[i]) push_byte(col_bytes[i]);
    if (mode == 3) repeat ($urandom_range(1, 3)) push_byte($urandom_range(0, 255));
  endtask

  // Wait until no request is pending or owed, then let the pipeline empty
  // of requests that cause no result.
  task automatic wait_quiet();
    do @(posedge clk);
    while (slab_requests.size() != 0 || in_valid || voxel_results_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_height(logic [7:0] h);
    cfg_valid <= 1'b1;
    cfg_data <= h;
    do @(posedge clk);
    while (!cfg_ready);
    vol_height = h;
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0] demo_col[18];
    int         heights[7];
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_height(8'd255);

    // Directed column: a stray byte before any column, a zero-length slab
    // before any color, a plain slab, a fill with the down face set, a slab
    // clipped at the volume top, and a stray byte after the column ends.
    demo_col = '{8'd10, 8'd0, 8'h00,
                 8'd0, 8'd2, 8'h00, 8'h00, 8'hFF,
                 8'd200, 8'd0, 8'(1 << vsc_pkg::DOWN_BIT),
                 8'd253, 8'd4, 8'(1 << vsc_pkg::UP_BIT), 8'h11, 8'h22, 8'h33, 8'h44};
    push_byte(8'h5A);
    push_begin(255, 255, 18);
    foreach (demo_col[i]) push_byte(demo_col[i]);
    push_byte(8'h80);

    // Random phases; each height change waits for the sender to drain.
    heights = '{1, 254, $urandom_range(1, 255), 2, 128, $urandom_range(1, 255), 255};
    foreach (heights[p]) begin
      wait_quiet();
      write_height(8'(heights[p]));
      for (int goal = item_count + PHASE_ITEMS; item_count < goal; ) gen_column();
    end

    wait_quiet();
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
